// ===== hdl/quicksort_lomuto_counting_core_macros.svh =====
// Assertion macros for the quicksort core.
// Used by the top level only; relies on nothing else.
`ifndef QUICKSORT_LOMUTO_COUNTING_CORE_MACROS_SVH
`define QUICKSORT_LOMUTO_COUNTING_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QSLC_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("quicksort core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QSLC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("quicksort core: next-cycle check failed");

`endif

// ===== hdl/qslc_pkg.sv =====
// Shared types and constants for the quicksort core.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package qslc_pkg;

    localparam int unsigned COUNT_WIDTH = 11;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_INIT,
        OP_POP,
        OP_RANGE,
        OP_PIVOT,
        OP_READ,
        OP_CMP,
        OP_SWAP2,
        OP_FINRD,
        OP_FINWR1,
        OP_FINWR2,
        OP_PUSHL,
        OP_PUSHR,
        OP_EMRD,
        OP_EMNEXT,
        OP_CLEAR
    } t_dp_op;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        logic sp_zero;
        logic j_done;
        logic swap;
        logic emit_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/qslc_ctrl.sv =====
// Sequencing state machine for the quicksort core.
// Depends on qslc_pkg for the command and status types.
`default_nettype none

module qslc_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_last,
    input  wire logic                  i_out_ready,
    input  wire qslc_pkg::t_dp_status  i_status,
    output qslc_pkg::t_dp_op           o_op,
    output logic                       o_in_ready,
    output logic                       o_out_valid
);
    import qslc_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_POPCHK,
        S_RANGE,
        S_PIVOT,
        S_LOOP,
        S_CMP,
        S_SWAP2,
        S_FIN1,
        S_FIN2,
        S_PUSHL,
        S_PUSHR,
        S_EMRD,
        S_EMOUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_IDLE;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    o_op = OP_LOAD;
                    if (i_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_op    = OP_INIT;
                n_state = S_POPCHK;
            end
            S_POPCHK: begin
                if (i_status.sp_zero) begin
                    n_state = S_EMRD;
                end else begin
                    o_op    = OP_POP;
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                o_op    = OP_RANGE;
                n_state = S_PIVOT;
            end
            S_PIVOT: begin
                o_op    = OP_PIVOT;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                if (i_status.j_done) begin
                    o_op    = OP_FINRD;
                    n_state = S_FIN1;
                end else begin
                    o_op    = OP_READ;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_op    = OP_CMP;
                n_state = i_status.swap ? S_SWAP2 : S_LOOP;
            end
            S_SWAP2: begin
                o_op    = OP_SWAP2;
                n_state = S_LOOP;
            end
            S_FIN1: begin
                o_op    = OP_FINWR1;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                o_op    = OP_FINWR2;
                n_state = S_PUSHL;
            end
            S_PUSHL: begin
                o_op    = OP_PUSHL;
                n_state = S_PUSHR;
            end
            S_PUSHR: begin
                o_op    = OP_PUSHR;
                n_state = S_POPCHK;
            end
            S_EMRD: begin
                o_op    = OP_EMRD;
                n_state = S_EMOUT;
            end
            S_EMOUT: begin
                if (i_out_ready) begin
                    if (i_status.emit_last) begin
                        o_op    = OP_CLEAR;
                        n_state = S_LOAD;
                    end else begin
                        o_op    = OP_EMNEXT;
                        n_state = S_EMRD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_EMOUT);

endmodule

`default_nettype wire

// ===== hdl/qslc_dpath.sv =====
// Datapath of the quicksort core: element store, range stack, indices and counters.
// Depends on qslc_pkg; driven one command per cycle by qslc_ctrl.
`default_nettype none

module qslc_dpath #(
    parameter int unsigned MAX_ITEMS   = 64,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire qslc_pkg::t_dp_op                  i_op,
    input  wire logic signed [VALUE_WIDTH-1:0]     i_value,
    output qslc_pkg::t_dp_status                   o_status,
    output logic signed [VALUE_WIDTH-1:0]          o_sorted_value,
    output logic [qslc_pkg::COUNT_WIDTH-1:0]       o_comparison_count,
    output logic                                   o_overflow,
    output logic                                   o_end_of_run
);
    import qslc_pkg::*;

    localparam int unsigned IW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    // Storage.
    logic [VALUE_WIDTH-1:0] r_store [MAX_ITEMS];
    logic [2*IW-1:0]        r_stack [MAX_ITEMS];

    // Registered read data.
    logic [VALUE_WIDTH-1:0] r_rd_a;
    logic [VALUE_WIDTH-1:0] r_rd_b;
    logic [2*IW-1:0]        r_stk_rd;
    logic [VALUE_WIDTH-1:0] r_pivot;

    // Control registers.
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_sp, n_sp;
    logic [COUNT_WIDTH-1:0] r_cmp, n_cmp;
    logic                   r_ovf, n_ovf;
    logic [IW-1:0]          r_lo, n_lo;
    logic [IW-1:0]          r_hi, n_hi;
    logic [IW-1:0]          r_j, n_j;
    logic [IW-1:0]          r_p, n_p;
    logic [IW-1:0]          r_k, n_k;

    // Memory port controls.
    logic                   st_we;
    logic [IW-1:0]          st_waddr;
    logic [VALUE_WIDTH-1:0] st_wdata;
    logic                   rd_a_en;
    logic [IW-1:0]          rd_a_addr;
    logic                   rd_b_en;
    logic [IW-1:0]          rd_b_addr;
    logic                   sk_we;
    logic [IW-1:0]          sk_waddr;
    logic [2*IW-1:0]        sk_wdata;
    logic                   sk_re;

    logic                   le;
    logic                   sp_full;
    logic [CW-1:0]          sp_dec;
    logic [CW-1:0]          count_dec;
    logic [IW:0]            p_inc;
    logic [IW:0]            lo_inc;
    logic [IW-1:0]          p_dec;

    assign le        = $signed(r_rd_a) <= $signed(r_pivot);
    assign sp_full   = (r_sp == CW'(MAX_ITEMS));
    assign sp_dec    = r_sp - CW'(1);
    assign count_dec = r_count - CW'(1);
    assign p_inc     = {1'b0, r_p} + (IW+1)'(1);
    assign lo_inc    = {1'b0, r_lo} + (IW+1)'(1);
    assign p_dec     = r_p - IW'(1);

    always_comb begin
        n_count   = r_count;
        n_sp      = r_sp;
        n_cmp     = r_cmp;
        n_ovf     = r_ovf;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_j       = r_j;
        n_p       = r_p;
        n_k       = r_k;
        st_we     = 1'b0;
        st_waddr  = r_p;
        st_wdata  = r_rd_a;
        rd_a_en   = 1'b0;
        rd_a_addr = r_j;
        rd_b_en   = 1'b0;
        rd_b_addr = r_p;
        sk_we     = 1'b0;
        sk_waddr  = r_sp[IW-1:0];
        sk_wdata  = {r_lo, p_dec};
        sk_re     = 1'b0;
        unique case (i_op)
            OP_IDLE: begin
            end
            OP_LOAD: begin
                if (r_count == CW'(MAX_ITEMS)) begin
                    n_ovf = 1'b1;
                end else begin
                    st_we    = 1'b1;
                    st_waddr = r_count[IW-1:0];
                    st_wdata = i_value;
                    n_count  = r_count + CW'(1);
                end
            end
            OP_INIT: begin
                n_k = '0;
                if (r_count >= CW'(2)) begin
                    sk_we    = 1'b1;
                    sk_waddr = '0;
                    sk_wdata = {IW'(0), count_dec[IW-1:0]};
                    n_sp     = CW'(1);
                end else begin
                    n_sp = '0;
                end
            end
            OP_POP: begin
                sk_re = 1'b1;
                n_sp  = sp_dec;
            end
            OP_RANGE: begin
                n_lo      = r_stk_rd[2*IW-1:IW];
                n_hi      = r_stk_rd[IW-1:0];
                n_j       = r_stk_rd[2*IW-1:IW];
                n_p       = r_stk_rd[2*IW-1:IW];
                rd_a_en   = 1'b1;
                rd_a_addr = r_stk_rd[IW-1:0];
            end
            OP_PIVOT: begin
            end
            OP_READ: begin
                rd_a_en = 1'b1;
                rd_b_en = 1'b1;
            end
            OP_CMP: begin
                if (r_cmp != COUNT_MAX) begin
                    n_cmp = r_cmp + COUNT_WIDTH'(1);
                end
                if (le) begin
                    n_p = p_inc[IW-1:0];
                    if (r_p != r_j) begin
                        // First half of the swap; the other half follows.
                        st_we = 1'b1;
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            OP_SWAP2: begin
                st_we    = 1'b1;
                st_waddr = r_j;
                st_wdata = r_rd_b;
                n_j      = r_j + IW'(1);
            end
            OP_FINRD: begin
                rd_b_en = 1'b1;
            end
            OP_FINWR1: begin
                st_we    = 1'b1;
                st_waddr = r_hi;
                st_wdata = r_rd_b;
            end
            OP_FINWR2: begin
                st_we    = 1'b1;
                st_wdata = r_pivot;
            end
            OP_PUSHL: begin
                if ({1'b0, r_p} > lo_inc && !sp_full) begin
                    sk_we = 1'b1;
                    n_sp  = r_sp + CW'(1);
                end
            end
            OP_PUSHR: begin
                sk_wdata = {p_inc[IW-1:0], r_hi};
                if (p_inc < {1'b0, r_hi} && !sp_full) begin
                    sk_we = 1'b1;
                    n_sp  = r_sp + CW'(1);
                end
            end
            OP_EMRD: begin
                rd_a_en   = 1'b1;
                rd_a_addr = r_k;
            end
            OP_EMNEXT: begin
                n_k = r_k + IW'(1);
            end
            OP_CLEAR: begin
                n_count = '0;
                n_sp    = '0;
                n_cmp   = '0;
                n_ovf   = 1'b0;
                n_k     = '0;
            end
            default: begin
            end
        endcase
    end

    // Element store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= st_wdata;
        end
        if (rd_a_en) begin
            r_rd_a <= r_store[rd_a_addr];
        end
        if (rd_b_en) begin
            r_rd_b <= r_store[rd_b_addr];
        end
    end

    // Range stack: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (sk_we) begin
            r_stack[sk_waddr] <= sk_wdata;
        end
        if (sk_re) begin
            r_stk_rd <= r_stack[sp_dec[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_PIVOT) begin
            r_pivot <= r_rd_a;
        end
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_j  <= n_j;
        r_p  <= n_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sp    <= '0;
            r_cmp   <= '0;
            r_ovf   <= 1'b0;
            r_k     <= '0;
        end else begin
            r_count <= n_count;
            r_sp    <= n_sp;
            r_cmp   <= n_cmp;
            r_ovf   <= n_ovf;
            r_k     <= n_k;
        end
    end

    assign o_status.sp_zero   = (r_sp == '0);
    assign o_status.j_done    = (r_j == r_hi);
    assign o_status.swap      = le && (r_p != r_j);
    assign o_status.emit_last = ({{(CW-IW){1'b0}}, r_k} == count_dec);

    assign o_sorted_value     = r_rd_a;
    assign o_comparison_count = r_cmp;
    assign o_overflow         = r_ovf;
    assign o_end_of_run       = o_status.emit_last;

endmodule

`default_nettype wire

// ===== hdl/quicksort_lomuto_counting_core.sv =====
// Each comparison is a read state followed by a compare state, and each swap adds a
// second write state through the single write port. Each range also passes through the
// pop, range, pivot, finish and push states; each sorted value is read, then offered.
// Reset (synchronous, active low) empties the block at once; no clearing pass.
`default_nettype none
`include "quicksort_lomuto_counting_core_macros.svh"

module quicksort_lomuto_counting_core #(
    parameter int unsigned MAX_ITEMS   = 64,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [VALUE_WIDTH-1:0]       i_value,
    input  wire logic                                i_last,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [VALUE_WIDTH-1:0]            o_sorted_value,
    output logic [qslc_pkg::COUNT_WIDTH-1:0]         o_comparison_count,
    output logic                                     o_overflow,
    output logic                                     o_end_of_run
);
    import qslc_pkg::*;

    // The block works in three phases. While loading, every input transfer
    // writes its value into the element store, or sets the overflow flag once
    // the store is full. The transfer marked last starts the sort.
    //
    // The sort pops pending ranges from the range stack and partitions each
    // one around its final element, Lomuto style: elements not greater than
    // the pivot are swapped to the left. Each comparison reads two entries,
    // and a swap takes two writes because the store has one write port.
    // The two sub-ranges are then pushed back if they hold two or more
    // elements and the stack has room.
    //
    // Finally the store is read out in order, each result read before it is
    // offered, and the counters are cleared on the final one.

    t_dp_op     op;
    t_dp_status status;

    // Result transfers split by whether they close the run.
    logic       out_last;
    logic       out_mid_run;

    qslc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last      (i_last),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_op        (op),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid)
    );

    qslc_dpath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op               (op),
        .i_value            (i_value),
        .o_status           (status),
        .o_sorted_value     (o_sorted_value),
        .o_comparison_count (o_comparison_count),
        .o_overflow         (o_overflow),
        .o_end_of_run       (o_end_of_run)
    );

    assign out_last    = o_valid && i_ready && o_end_of_run;
    assign out_mid_run = o_valid && i_ready && !o_end_of_run;

    // Loading and emitting never overlap.
    `QSLC_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)

    // The block is ready for a new run straight after the final result.
    `QSLC_ASSERT_NEXT(a_ready_after_run, i_clk, i_rst_n, out_last, o_ready)

    // The count and overflow flag stay fixed across the results of one run.
    `QSLC_ASSERT_NEXT(a_count_fixed, i_clk, i_rst_n, out_mid_run, $stable(o_comparison_count))
    `QSLC_ASSERT_NEXT(a_overflow_fixed, i_clk, i_rst_n, out_mid_run, $stable(o_overflow))

endmodule

`default_nettype wire
